// ----- design/ps2kc_pkg.sv -----
`default_nettype none
package ps2kc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] addr_t;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_DEV   = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  localparam addr_t A_CMD     = 5'h00;
  localparam addr_t A_STATUS  = 5'h01;
  localparam addr_t A_OBF     = 5'h02;
  localparam addr_t A_LASTCMD = 5'h03;
  localparam addr_t A_GOTREL  = 5'h04;
  localparam addr_t A_OUTPORT = 5'h05;
  localparam addr_t A_PWCOUNT = 5'h06;
  localparam addr_t A_PWCMP   = 5'h07;
  localparam addr_t A_PWFIRST = 5'h08;
  localparam addr_t A_SECON   = 5'h13;
  localparam addr_t A_SECOFF  = 5'h14;
  localparam addr_t A_MAKE1   = 5'h16;
  localparam addr_t A_MAKE2   = 5'h17;

  localparam byte_t PW_MAXIDX = 8'd6;
  localparam byte_t PW_FULL   = 8'd15;

  localparam byte_t CMD_PW_TEST   = 8'ha4;
  localparam byte_t CMD_PW_INST   = 8'ha5;
  localparam byte_t CMD_PW_ENABLE = 8'ha6;
  localparam byte_t CMD_AUX_DIS   = 8'ha7;
  localparam byte_t CMD_AUX_EN    = 8'ha8;
  localparam byte_t CMD_AUX_TEST  = 8'ha9;
  localparam byte_t CMD_SELF_TEST = 8'haa;
  localparam byte_t CMD_KBD_TEST  = 8'hab;
  localparam byte_t CMD_KBD_DIS   = 8'had;
  localparam byte_t CMD_KBD_EN    = 8'hae;
  localparam byte_t CMD_RD_INPORT = 8'hc0;
  localparam byte_t CMD_RD_OUTP   = 8'hd0;
  localparam byte_t CMD_WR_OUTP   = 8'hd1;
  localparam byte_t CMD_WR_KBDBUF = 8'hd2;
  localparam byte_t CMD_WR_AUXBUF = 8'hd3;
  localparam byte_t CMD_WR_AUX    = 8'hd4;
  localparam byte_t CMD_A20_OFF   = 8'hdd;
  localparam byte_t CMD_A20_ON    = 8'hdf;
  localparam byte_t CMD_RD_TEST   = 8'he0;
  localparam byte_t CMD_PULSE     = 8'hf0;
  localparam byte_t CMD_RD_FIRST  = 8'h20;
  localparam byte_t CMD_RD_LAST   = 8'h3f;
  localparam byte_t CMD_WR_FIRST  = 8'h60;
  localparam byte_t CMD_WR_LAST   = 8'h7f;

  localparam byte_t BYTE_RELEASE = 8'hf0;
  localparam byte_t BYTE_ACK     = 8'hfa;
  localparam byte_t BYTE_NOPW    = 8'hf1;
  localparam byte_t BYTE_TEST_OK = 8'h55;

  typedef struct packed {
    byte_t cmd;
    byte_t status;
    byte_t obf;
    byte_t lastcmd;
    byte_t gotrel;
    byte_t outport;
    byte_t pwcount;
    byte_t pwcmp;
    byte_t pw0;
    byte_t secon;
    byte_t secoff;
    byte_t make1;
    byte_t make2;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{cmd: 8'h41, status: 8'h10, outport: 8'h03, default: '0};

  typedef struct packed {
    logic  we;
    addr_t addr;
    byte_t data;
  } mem_wr_t;

  typedef struct packed {
    byte_t read_data;
    logic  taken;
    logic  want_kbd;
    logic  want_aux;
    logic  irq_kbd;
    logic  irq_aux;
    logic  a20_gate;
    logic  rst_req;
    logic  kbd_send;
    logic  aux_send;
    byte_t send_byte;
  } res_t;

  localparam byte_t SC_TABLE [128] = '{
    8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58,
    8'h64, 8'h44, 8'h42, 8'h40, 8'h3e, 8'h0f, 8'h29, 8'h59,
    8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
    8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b,
    8'h67, 8'h2e, 8'h2d, 8'h20, 8'h12, 8'h05, 8'h04, 8'h5c,
    8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
    8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e,
    8'h6a, 8'h72, 8'h32, 8'h24, 8'h16, 8'h08, 8'h09, 8'h5f,
    8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
    8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61,
    8'h6d, 8'h73, 8'h28, 8'h74, 8'h1a, 8'h0d, 8'h62, 8'h6e,
    8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
    8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b,
    8'h7c, 8'h4f, 8'h7d, 8'h4b, 8'h47, 8'h7e, 8'h7f, 8'h6f,
    8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
    8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54
  };

  function automatic byte_t xlate(input byte_t v);
    byte_t r;
    if (!v[7]) begin
      r = SC_TABLE[v[6:0]];
    end else if (v == 8'h83) begin
      r = 8'h41;
    end else if (v == 8'h84) begin
      r = 8'h54;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Addresses kept in flops; all others live in the RAM.
  function automatic logic is_ctrl(input addr_t a);
    return (a <= A_PWFIRST) || (a inside {A_SECON, A_SECOFF, A_MAKE1, A_MAKE2});
  endfunction

  function automatic byte_t ctrl_rd(input ctrl_t c, input addr_t a);
    byte_t r;
    case (a)
      A_CMD:     r = c.cmd;
      A_STATUS:  r = c.status;
      A_OBF:     r = c.obf;
      A_LASTCMD: r = c.lastcmd;
      A_GOTREL:  r = c.gotrel;
      A_OUTPORT: r = c.outport;
      A_PWCOUNT: r = c.pwcount;
      A_PWCMP:   r = c.pwcmp;
      A_PWFIRST: r = c.pw0;
      A_SECON:   r = c.secon;
      A_SECOFF:  r = c.secoff;
      A_MAKE1:   r = c.make1;
      A_MAKE2:   r = c.make2;
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic ctrl_t ctrl_wr(input ctrl_t c, input addr_t a, input byte_t v);
    ctrl_t r;
    r = c;
    case (a)
      A_CMD:     r.cmd = v;
      A_STATUS:  r.status = v;
      A_OBF:     r.obf = v;
      A_LASTCMD: r.lastcmd = v;
      A_GOTREL:  r.gotrel = v;
      A_OUTPORT: r.outport = v;
      A_PWCOUNT: r.pwcount = v;
      A_PWCMP:   r.pwcmp = v;
      A_PWFIRST: r.pw0 = v;
      A_SECON:   r.secon = v;
      A_SECOFF:  r.secoff = v;
      A_MAKE1:   r.make1 = v;
      A_MAKE2:   r.make2 = v;
      default:   r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/ps2kc_ram.sv -----
`default_nettype none
module ps2kc_ram
  import ps2kc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    clear,
  input  wire mem_wr_t wr,
  input  wire logic    re,
  input  wire addr_t   raddr_a,
  input  wire addr_t   raddr_b,
  output byte_t        rdata_a,
  output byte_t        rdata_b
);

  byte_t       mem [32];
  logic [31:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (clear) begin
      vld <= '0;
    end else if (wr.we) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= vld[raddr_a] ? mem[raddr_a] : '0;
      rdata_b <= vld[raddr_b] ? mem[raddr_b] : '0;
    end
  end

endmodule
`default_nettype wire

// ----- design/ps2kc_step.sv -----
`default_nettype none
module ps2kc_step
  import ps2kc_pkg::*;
(
  input  wire ctrl_t   ctrl,
  input  wire logic [1:0] req_type,
  input  wire logic    port_sel,
  input  wire byte_t   write_data,
  input  wire byte_t   dev_byte,
  input  wire logic    dev_is_aux,
  input  wire byte_t   mem_a,
  input  wire byte_t   mem_b,
  output ctrl_t        ctrl_next,
  output mem_wr_t      mem_wr,
  output logic         mem_clear,
  output res_t         res
);

  ctrl_t c;
  res_t  r;
  logic  dv_en, dv_aux, go, handled, post_clr, en;
  byte_t dv_val, v, lc, pa_val, pb_val, ncmp, st;
  addr_t pa, pb, wa;

  always_comb begin
    c        = ctrl;
    r        = '0;
    mem_wr   = '0;
    mem_clear = 1'b0;
    dv_en    = 1'b0;
    dv_aux   = 1'b0;
    dv_val   = '0;
    handled  = 1'b0;
    post_clr = 1'b0;
    en       = 1'b0;
    lc       = ctrl.lastcmd;
    wa       = '0;
    go       = 1'b0;
    v        = '0;
    pa       = '0;
    pb       = '0;
    pa_val   = '0;
    pb_val   = '0;
    ncmp     = '0;
    st       = '0;

    case (req_type)
      REQ_READ: begin
        if (!port_sel) begin
          r.read_data = c.obf;
          c.status    = c.status & ~8'h21;
          c.outport   = c.outport & ~8'h30;
        end else begin
          r.read_data = (c.status & ~8'h04) | (c.cmd & 8'h04);
        end
      end
      REQ_WRITE: begin
        if (c.status[4]) begin
          if (!port_sel) begin
            post_clr = 1'b1;
            handled  = c.status[3];
            if (c.status[3]) begin
              if (lc inside {[CMD_WR_FIRST:CMD_WR_LAST]}) begin
                wa = lc[4:0];
                if (is_ctrl(wa)) begin
                  c = ctrl_wr(c, wa, write_data);
                end else begin
                  mem_wr = '{we: 1'b1, addr: wa, data: write_data};
                end
              end else if (lc == CMD_PW_INST) begin
                if (c.pwcount <= PW_MAXIDX) begin
                  wa = A_PWFIRST + c.pwcount[4:0];
                  if (is_ctrl(wa)) begin
                    c = ctrl_wr(c, wa, write_data);
                  end else begin
                    mem_wr = '{we: 1'b1, addr: wa, data: write_data};
                  end
                  c.pwcount = (write_data == '0) ? PW_FULL : c.pwcount + 8'd1;
                end
              end else if (lc == CMD_WR_OUTP) begin
                c.outport = write_data;
                r.rst_req = !write_data[0];
              end else if (lc == CMD_WR_KBDBUF) begin
                dv_en  = 1'b1;
                dv_val = write_data;
              end else if (lc == CMD_WR_AUXBUF) begin
                dv_en  = 1'b1;
                dv_aux = 1'b1;
                dv_val = write_data;
              end else if (lc == CMD_WR_AUX) begin
                r.aux_send  = 1'b1;
                r.send_byte = write_data;
              end else if (lc == CMD_A20_OFF) begin
                c.outport[1] = 1'b0;
              end else if (lc == CMD_A20_ON) begin
                c.outport[1] = 1'b1;
              end else begin
                handled = 1'b0;
              end
            end
            if (!handled) begin
              r.kbd_send  = 1'b1;
              r.send_byte = write_data;
            end
          end else begin
            c.lastcmd   = write_data;
            c.status[3] = 1'b1;
            if (write_data inside {[CMD_RD_FIRST:CMD_RD_LAST]}) begin
              dv_en  = 1'b1;
              dv_val = is_ctrl(write_data[4:0]) ? ctrl_rd(c, write_data[4:0]) : mem_a;
            end else if (write_data >= CMD_PULSE) begin
              r.rst_req = !write_data[0];
            end else begin
              case (write_data)
                CMD_PW_TEST: begin
                  dv_en  = 1'b1;
                  dv_val = (c.pwcount != '0) ? BYTE_ACK : BYTE_NOPW;
                end
                CMD_PW_ENABLE: begin
                  c.status[4] = 1'b0;
                  c.pwcmp     = '0;
                  if (c.secon != '0) begin
                    c.obf       = c.secon;
                    c.status    = (c.status & ~8'h21) | 8'h01;
                    r.irq_kbd   = c.cmd[0];
                  end
                end
                CMD_AUX_DIS: c.cmd[5] = 1'b1;
                CMD_AUX_EN:  c.cmd[5] = 1'b0;
                CMD_AUX_TEST, CMD_KBD_TEST, CMD_RD_INPORT, CMD_RD_TEST: begin
                  dv_en  = 1'b1;
                  dv_val = '0;
                end
                CMD_SELF_TEST: begin
                  dv_en  = 1'b1;
                  dv_val = BYTE_TEST_OK;
                end
                CMD_KBD_DIS: c.cmd[4] = 1'b1;
                CMD_KBD_EN:  c.cmd[4] = 1'b0;
                CMD_RD_OUTP: begin
                  dv_en  = 1'b1;
                  dv_val = c.outport;
                end
                default: ;
              endcase
            end
          end
        end
      end
      REQ_DEV: begin
        en = dev_is_aux ? !c.cmd[5] : !c.cmd[4];
        if (!c.status[0] && en) begin
          r.taken = 1'b1;
          dv_en   = 1'b1;
          dv_aux  = dev_is_aux;
          dv_val  = dev_byte;
        end
      end
      default: begin
        c         = CTRL_RESET;
        mem_clear = 1'b1;
      end
    endcase

    // Deliver a byte into the output buffer.
    if (dv_en) begin
      v  = dv_val;
      go = 1'b1;
      if (!dv_aux && c.cmd[6]) begin
        if (v == BYTE_RELEASE) begin
          c.gotrel = 8'd1;
          go       = 1'b0;
        end else begin
          v = xlate(v);
          if (c.gotrel != '0) begin
            v[7] = 1'b1;
          end
          c.gotrel = '0;
        end
      end
      // Password lock swallows bytes until the password matches.
      if (go && !c.status[4]) begin
        go = 1'b0;
        if (!(v[7] || v == c.make1 || v == c.make2 || dv_aux)) begin
          pa     = A_PWFIRST + c.pwcmp[4:0];
          pb     = pa + 5'd1;
          pa_val = is_ctrl(pa) ? ctrl_rd(c, pa) : mem_a;
          ncmp   = (v == pa_val) ? c.pwcmp + 8'd1 : '0;
          c.pwcmp = ncmp;
          if (ncmp == '0) begin
            pb_val = c.pw0;
          end else begin
            pb_val = is_ctrl(pb) ? ctrl_rd(c, pb) : mem_b;
          end
          if (ncmp > PW_MAXIDX || pb_val == '0) begin
            c.status[4] = 1'b1;
            if (c.secoff != '0) begin
              v  = c.secoff;
              go = 1'b1;
            end
          end
        end
      end
      if (go) begin
        c.obf    = v;
        st       = (c.status & ~8'h21) | (dv_aux ? 8'h21 : 8'h01);
        c.status = st;
        if (st[5] && st[0] && c.cmd[1]) begin
          c.outport[5] = 1'b1;
          r.irq_aux    = 1'b1;
        end else if (!st[5] && st[0] && c.cmd[0]) begin
          c.outport[4] = 1'b1;
          r.irq_kbd    = 1'b1;
        end
      end
    end

    if (post_clr) begin
      c.status[3] = 1'b0;
    end

    r.want_kbd = !c.status[0] && !c.cmd[4];
    r.want_aux = !c.status[0] && !c.cmd[5];
    r.a20_gate = c.outport[1];
    ctrl_next  = c;
    res        = r;
  end

endmodule
`default_nettype wire

// ----- design/ps2_keyboard_controller.sv -----
`default_nettype none
// A request enters the update stage at accept (RAM read at accept), then its result
// goes to the result register. No new request is accepted while one is in the update
// stage; the result register lets the next request enter while a result waits.
// Reset (rst, synchronous): control bytes to defaults, RAM reads as zero,
// pipeline and result register empty. A controller-reset request resets control and RAM.
module ps2_keyboard_controller
  import ps2kc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] req_type,
  input  wire logic       port_sel,
  input  wire logic [7:0] write_data,
  input  wire logic [7:0] dev_byte,
  input  wire logic       dev_is_aux,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      read_data,
  output logic            dev_byte_taken,
  output logic            want_kbd,
  output logic            want_aux,
  output logic            irq_kbd_pulse,
  output logic            irq_aux_pulse,
  output logic            a20_gate,
  output logic            reset_pulse,
  output logic            kbd_send_valid,
  output logic            aux_send_valid,
  output logic [7:0]      send_byte
);

  ctrl_t      ctrl, ctrl_next;
  logic       s1_valid, in_acc, s1_done, mem_clear;
  logic [1:0] s1_req;
  logic       s1_port, s1_aux;
  byte_t      s1_wd, s1_db, mem_a, mem_b;
  addr_t      raddr_a, raddr_b;
  mem_wr_t    mem_wr, ram_wr;
  res_t       res, res_q;

  assign in_stall = s1_valid;
  assign in_acc   = in_valid && !in_stall;
  assign s1_done  = s1_valid && !(out_valid && out_stall);

  assign raddr_a = (req_type == REQ_WRITE && port_sel) ? write_data[4:0]
                                                       : A_PWFIRST + ctrl.pwcmp[4:0];
  assign raddr_b = A_PWFIRST + ctrl.pwcmp[4:0] + 5'd1;

  assign ram_wr.we   = mem_wr.we && s1_done;
  assign ram_wr.addr = mem_wr.addr;
  assign ram_wr.data = mem_wr.data;

  ps2kc_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .clear   (mem_clear && s1_done),
    .wr      (ram_wr),
    .re      (in_acc),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (mem_a),
    .rdata_b (mem_b)
  );

  ps2kc_step u_step (
    .ctrl       (ctrl),
    .req_type   (s1_req),
    .port_sel   (s1_port),
    .write_data (s1_wd),
    .dev_byte   (s1_db),
    .dev_is_aux (s1_aux),
    .mem_a      (mem_a),
    .mem_b      (mem_b),
    .ctrl_next  (ctrl_next),
    .mem_wr     (mem_wr),
    .mem_clear  (mem_clear),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      ctrl      <= CTRL_RESET;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        out_valid <= 1'b1;
        ctrl      <= ctrl_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req  <= req_type;
      s1_port <= port_sel;
      s1_wd   <= write_data;
      s1_db   <= dev_byte;
      s1_aux  <= dev_is_aux;
    end
    if (s1_done) begin
      res_q <= res;
    end
  end

  assign read_data      = res_q.read_data;
  assign dev_byte_taken = res_q.taken;
  assign want_kbd       = res_q.want_kbd;
  assign want_aux       = res_q.want_aux;
  assign irq_kbd_pulse  = res_q.irq_kbd;
  assign irq_aux_pulse  = res_q.irq_aux;
  assign a20_gate       = res_q.a20_gate;
  assign reset_pulse    = res_q.rst_req;
  assign kbd_send_valid = res_q.kbd_send;
  assign aux_send_valid = res_q.aux_send;
  assign send_byte      = res_q.send_byte;

  a_acc_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> s1_valid)
    else $error("accepted request did not enter update stage");

  a_wr_on_done: assert property (@(posedge clk) disable iff (rst)
    (mem_wr.we && s1_valid && !s1_done) |=> $stable(s1_wd))
    else $error("stalled update stage lost its request");

  a_ctrl_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_done |=> $stable(ctrl))
    else $error("control bytes changed without a completed update");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(res_q))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
